@@ hdl/ultrasonic_range_filter_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic range filter
// Shared wrappers around concurrent assertions clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_FILTER_MACROS_SVH
`define ULTRASONIC_RANGE_FILTER_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define URF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define URF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define URF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/urf_pkg.sv @@
// ----------------------------------------------------------------------------
// urf_pkg
// Shared types and constants of the ultrasonic range filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package urf_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int SENSOR_W     = 2;
    localparam int REG_W        = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int TIME_W       = 16;
    localparam int RANGE_W      = 18;
    localparam int STATUS_W     = 3;
    localparam int SAMPLES_W    = 2;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RANGE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_THR = 2'd1;

    localparam logic [REG_W-1:0] RESET_MAX_CM = 10'd400;
    localparam logic [REG_W-1:0] RESET_THR_CM = 10'd30;

    localparam logic [SAMPLES_W-1:0] SAMPLES_FULL = 2'd2;

    // sensor positions
    localparam logic [SENSOR_W-1:0] SNS_FRONT = 2'd0;
    localparam logic [SENSOR_W-1:0] SNS_RIGHT = 2'd1;
    localparam logic [SENSOR_W-1:0] SNS_BACK  = 2'd2;
    localparam logic [SENSOR_W-1:0] SNS_LEFT  = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        OBS_CLEAR      = 3'd0,
        OBS_TRAPPED    = 3'd1,
        OBS_BOTH_SIDES = 3'd2,
        OBS_FRONT      = 3'd3,
        OBS_LEFT       = 3'd4,
        OBS_RIGHT      = 3'd5,
        OBS_REAR       = 3'd6
    } t_obstacle;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MIX,
        ST_DIVY,
        ST_SUM,
        ST_DIVZ,
        ST_WB
    } t_state;

    typedef struct packed {
        logic                rd_en;
        logic [SENSOR_W-1:0] rd_addr;
        logic                wr_en;
        logic [SENSOR_W-1:0] wr_addr;
    } t_mem_ctl;

endpackage

`default_nettype wire

@@ hdl/urf_state_mem.sv @@
// ----------------------------------------------------------------------------
// urf_state_mem
// Per-sensor state memory, registered read, valid bit per entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urf_state_mem #(
    parameter int               EW       = 56,
    parameter logic [EW-1:0]    RST_WORD = '0
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire urf_pkg::t_mem_ctl i_ctl,
    input  wire  [EW-1:0]          i_wr_data,
    output logic [EW-1:0]          o_rd_data
);
    import urf_pkg::*;

    logic [EW-1:0]           mem [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] r_valid;
    logic [EW-1:0]           r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_ctl.rd_addr];
            end
        end
    end

    // never-written entry reads as the reset contents
    assign o_rd_data = r_rd_valid ? r_rd_data : RST_WORD;

endmodule

`default_nettype wire

@@ hdl/urf_raw_conv.sv @@
// ----------------------------------------------------------------------------
// urf_raw_conv
// Echo time to fixed-point range: t*10*2^F/582 by reciprocal, range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urf_raw_conv #(
    parameter int FRACTION_BITS = 8
) (
    input  wire                           i_clk,
    input  wire                           i_en,
    input  wire  [urf_pkg::TIME_W-1:0]    i_time,
    input  wire                           i_seen,
    input  wire  [urf_pkg::REG_W-1:0]     i_max,
    output logic [FRACTION_BITS+9:0]      o_raw
);
    import urf_pkg::*;

    localparam int RW          = REG_W + FRACTION_BITS;
    localparam int XW          = 19 + FRACTION_BITS;
    localparam int RECIP_SHIFT = 40;
    // ceil(2^40 / 291); exact quotient for every numerator below 2^31
    localparam logic [31:0] RECIP = 32'(((64'd1 << RECIP_SHIFT) + 64'd290) / 64'd291);
    localparam logic [RW-1:0] TWO_FX = RW'(2) << FRACTION_BITS;

    logic [18:0]      t5;
    logic [XW-1:0]    x;
    logic [19:0]      t10;
    logic [19:0]      top;
    logic [XW+31:0]   r_prod;
    logic             r_high;
    logic [RW-1:0]    q;
    logic [RW-1:0]    max_fx;

    assign t5     = {i_time, 2'b00} + 19'(i_time);
    assign x      = {t5, {FRACTION_BITS{1'b0}}};
    assign t10    = {t5, 1'b0};
    assign top    = 20'(i_max) * 20'd582;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {32'b0, x} * {{XW{1'b0}}, RECIP};
            r_high <= t10 > top;
        end
    end

    // quotient fits RW bits whenever the upper limit check passes
    assign q      = r_prod[RECIP_SHIFT +: RW];
    assign max_fx = {i_max, {FRACTION_BITS{1'b0}}};
    assign o_raw  = (!i_seen || r_high || q < TWO_FX) ? max_fx : q;

endmodule

`default_nettype wire

@@ hdl/urf_div5.sv @@
// ----------------------------------------------------------------------------
// urf_div5
// Floor divide by five: registered multiply by reciprocal, then shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urf_div5 #(
    parameter int W  = 21,
    parameter int OW = 18
) (
    input  wire             i_clk,
    input  wire             i_en,
    input  wire  [W-1:0]    i_num,
    output logic [OW-1:0]   o_quot
);
    localparam int S = W + 3;
    // ceil(2^S / 5); error below 1/8 keeps the floor exact
    localparam logic [W:0] RECIP = (W+1)'(((64'd1 << S) + 64'd4) / 64'd5);

    logic [2*W:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{(W+1){1'b0}}, i_num} * {{W{1'b0}}, RECIP};
        end
    end

    assign o_quot = r_prod[S +: OW];

endmodule

`default_nettype wire

@@ hdl/urf_status.sv @@
// ----------------------------------------------------------------------------
// urf_status
// Obstacle status from the four smoothed ranges, fixed priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urf_status #(
    parameter int FRACTION_BITS = 8
) (
    input  wire  [urf_pkg::SENSOR_COUNT-1:0][FRACTION_BITS+9:0] i_filt,
    input  wire  [urf_pkg::REG_W-1:0]                           i_thr,
    output urf_pkg::t_obstacle                                  o_status
);
    import urf_pkg::*;

    localparam int RW = REG_W + FRACTION_BITS;

    logic [RW-1:0]           thr_fx;
    logic [SENSOR_COUNT-1:0] blk;
    logic [2:0]              cnt;

    assign thr_fx = {i_thr, {FRACTION_BITS{1'b0}}};

    always_comb begin
        cnt = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            blk[k] = i_filt[k] < thr_fx;
            cnt    = cnt + 3'(blk[k]);
        end
    end

    always_comb begin
        if (cnt >= 3'd3) begin
            o_status = OBS_TRAPPED;
        end else if (blk[SNS_LEFT] && blk[SNS_RIGHT]) begin
            o_status = OBS_BOTH_SIDES;
        end else if (blk[SNS_FRONT]) begin
            o_status = OBS_FRONT;
        end else if (blk[SNS_LEFT]) begin
            o_status = OBS_LEFT;
        end else if (blk[SNS_RIGHT]) begin
            o_status = OBS_RIGHT;
        end else if (blk[SNS_BACK]) begin
            o_status = OBS_REAR;
        end else begin
            o_status = OBS_CLEAR;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ultrasonic_range_filter.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_range_filter
// Four-sensor echo range filter: conversion, spike filter, EMA, status.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+------------------------------
//  in       | to block  | i_in_valid / o_in_ready    | sensor, echo seen, echo time
//  out      | from block| o_out_valid / i_out_ready  | sensor, raw, smoothed, status
//  cfg      | to block  | i_cfg_valid / o_cfg_ready  | register index, data
//
//  One word at a time: accept, then conversion multiply, filter select,
//  divide-by-five for the drop weighting, EMA sum, divide-by-five for the
//  EMA, write-back. The single state-memory read/modify/write sets this.
//  Synchronous active-low reset clears the control state and the entry
//  valid bits; an unwritten entry reads as the reset range.
//  The result sits in an output register; the next word is accepted while
//  it waits. Write-back holds until the output register is free.
//  The cfg channel is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_range_filter #(
    parameter int FRACTION_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [urf_pkg::SENSOR_W-1:0]     i_sensor_index,
    input  wire                              i_echo_seen,
    input  wire  [urf_pkg::TIME_W-1:0]       i_echo_time_us,

    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [urf_pkg::SENSOR_W-1:0]     o_sensor_out,
    output logic [urf_pkg::RANGE_W-1:0]      o_raw_range,
    output logic [urf_pkg::RANGE_W-1:0]      o_smoothed_range,
    output logic [urf_pkg::STATUS_W-1:0]     o_obstacle_status,

    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [urf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire  [urf_pkg::REG_W-1:0]        i_cfg_data
);
    import urf_pkg::*;

    // full-precision range width; outputs keep the low 18 bits
    localparam int RW = REG_W + FRACTION_BITS;
    localparam int DW = RW + 3;
    localparam int EW = 3 * RW + SAMPLES_W;

    // entry layout: {current, previous, samples, filtered}
    localparam int FILT_LSB = 0;
    localparam int SAMP_LSB = RW;
    localparam int PREV_LSB = RW + SAMPLES_W;
    localparam int CUR_LSB  = 2 * RW + SAMPLES_W;

    localparam logic [RW-1:0] RST_FX     = RW'(RESET_MAX_CM) << FRACTION_BITS;
    localparam logic [RW-1:0] FIFTEEN_FX = RW'(15) << FRACTION_BITS;
    localparam logic [EW-1:0] RST_WORD   = {RST_FX, RST_FX, {SAMPLES_W{1'b0}}, RST_FX};

    // control
    t_state r_state, n_state;

    // configuration registers
    logic [REG_W-1:0] r_max_cm;
    logic [REG_W-1:0] r_thr_cm;

    // captured input word
    logic [SENSOR_W-1:0] r_s;
    logic                r_seen;
    logic [TIME_W-1:0]   r_time;

    // filter pipeline registers
    logic [RW-1:0]        r_raw;
    logic [RW-1:0]        r_prev_new;
    logic [SAMPLES_W-1:0] r_samp_new;
    logic                 r_first;
    logic                 r_drop;
    logic [RW-1:0]        r_avg;
    logic [DW-1:0]        r_y;
    logic [DW-1:0]        r_z4;

    // smoothed range mirror for the status compare
    logic [SENSOR_COUNT-1:0][RW-1:0] r_filt;
    logic [SENSOR_COUNT-1:0][RW-1:0] filt_view;

    // output register
    logic                  r_out_valid;
    logic [SENSOR_W-1:0]   r_out_s;
    logic [RANGE_W-1:0]    r_out_raw;
    logic [RANGE_W-1:0]    r_out_smooth;
    logic [STATUS_W-1:0]   r_out_status;

    // datapath nets
    logic                 in_acc;
    logic                 out_free;
    logic                 wb_go;
    t_mem_ctl             mem_ctl;
    logic [EW-1:0]        rd_word;
    logic [EW-1:0]        wr_word;
    logic [RW-1:0]        e_cur;
    logic [SAMPLES_W-1:0] e_samp;
    logic [RW-1:0]        e_filt;
    logic [RW-1:0]        raw;
    logic [RW-1:0]        diff;
    logic [DW-1:0]        diff5;
    logic                 consistent;
    logic [RW:0]          pair_sum;
    logic [DW-1:0]        y;
    logic [SAMPLES_W-1:0] samp_new;
    logic [RW-1:0]        quot;
    logic [DW-1:0]        div_num;
    logic                 div_en;
    logic [RW-1:0]        v;
    logic [RW+4:0]        z;
    t_obstacle            status;
    logic [RW+RANGE_W-1:0] raw_ext;
    logic [RW+RANGE_W-1:0] smooth_ext;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign wb_go    = (r_state == ST_WB) && out_free;

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: n_state = ST_MIX;
            ST_MIX:  n_state = ST_DIVY;
            ST_DIVY: n_state = ST_SUM;
            ST_SUM:  n_state = ST_DIVZ;
            ST_DIVZ: n_state = ST_WB;
            ST_WB: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cm <= RESET_MAX_CM;
            r_thr_cm <= RESET_THR_CM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_RANGE: r_max_cm <= i_cfg_data;
                REG_BLOCK_THR: r_thr_cm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- state memory ----------------
    // read on accept, write back at the end: one item in flight, no overlap
    assign mem_ctl.rd_en   = in_acc;
    assign mem_ctl.rd_addr = i_sensor_index;
    assign mem_ctl.wr_en   = wb_go;
    assign mem_ctl.wr_addr = r_s;
    assign wr_word         = {r_raw, r_prev_new, r_samp_new, quot};

    urf_state_mem #(
        .EW       (EW),
        .RST_WORD (RST_WORD)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_data (wr_word),
        .o_rd_data (rd_word)
    );

    assign e_cur  = rd_word[CUR_LSB +: RW];
    assign e_samp = rd_word[SAMP_LSB +: SAMPLES_W];
    assign e_filt = rd_word[FILT_LSB +: RW];

    // ---------------- input capture ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s    <= i_sensor_index;
            r_seen <= i_echo_seen;
            r_time <= i_echo_time_us;
        end
    end

    // ---------------- raw conversion (CONV) ----------------
    urf_raw_conv #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_conv (
        .i_clk  (i_clk),
        .i_en   (r_state == ST_CONV),
        .i_time (r_time),
        .i_seen (r_seen),
        .i_max  (r_max_cm),
        .o_raw  (raw)
    );

    // ---------------- spike filter select (MIX) ----------------
    // current = new raw, previous = stored current
    assign diff       = (raw > e_cur) ? (raw - e_cur) : (e_cur - raw);
    assign diff5      = {diff, 2'b00} + DW'(diff);
    assign consistent = (diff < FIFTEEN_FX) || (diff5 < DW'(e_cur));
    assign pair_sum   = {1'b0, raw} + {1'b0, e_cur};
    // 2c + 3p for the drop weighting
    assign y          = DW'({raw, 1'b0}) + DW'({e_cur, 1'b0}) + DW'(e_cur);
    assign samp_new   = (e_samp < SAMPLES_FULL) ? (e_samp + 2'd1) : SAMPLES_FULL;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MIX) begin
            r_raw      <= raw;
            r_prev_new <= e_cur;
            r_samp_new <= samp_new;
            r_first    <= samp_new < SAMPLES_FULL;
            r_drop     <= !consistent && (raw < e_cur);
            r_avg      <= pair_sum[RW:1];
            r_y        <= y;
        end
    end

    // ---------------- shared divide by five (DIVY, DIVZ) ----------------
    assign div_en  = (r_state == ST_DIVY) || (r_state == ST_DIVZ);
    assign div_num = (r_state == ST_DIVZ) ? r_z4 : r_y;

    urf_div5 #(
        .W  (DW),
        .OW (RW)
    ) u_div5 (
        .i_clk  (i_clk),
        .i_en   (div_en),
        .i_num  (div_num),
        .o_quot (quot)
    );

    // ---------------- EMA sum (SUM) ----------------
    // first sample passes raw through; 13 s + 7 v, /20 = (>>2) then /5
    assign v = r_first ? r_raw : (r_drop ? quot : r_avg);
    assign z = ({e_filt, 3'b000} + {1'b0, e_filt, 2'b00} + (RW+5)'(e_filt))
             + ({1'b0, v, 3'b000} - (RW+5)'(v));

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            r_z4 <= z[RW+4:2];
        end
    end

    // ---------------- status and write-back (WB) ----------------
    always_comb begin
        filt_view      = r_filt;
        filt_view[r_s] = quot;
    end

    urf_status #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_status (
        .i_filt   (filt_view),
        .i_thr    (r_thr_cm),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                r_filt[k] <= RST_FX;
            end
        end else if (wb_go) begin
            r_filt[r_s] <= quot;
        end
    end

    assign raw_ext    = {{RANGE_W{1'b0}}, r_raw};
    assign smooth_ext = {{RANGE_W{1'b0}}, quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            r_out_s      <= r_s;
            r_out_raw    <= raw_ext[RANGE_W-1:0];
            r_out_smooth <= smooth_ext[RANGE_W-1:0];
            r_out_status <= status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sensor_out      = r_out_s;
    assign o_raw_range       = r_out_raw;
    assign o_smoothed_range  = r_out_smooth;
    assign o_obstacle_status = r_out_status;

endmodule

`default_nettype wire

@@ hdl/urf_checker.sv @@
// ----------------------------------------------------------------------------
// urf_checker
// Port-level checks of the ultrasonic range filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ultrasonic_range_filter_macros.svh"

module urf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [1:0]  o_sensor_out,
    input wire [17:0] o_raw_range,
    input wire [17:0] o_smoothed_range,
    input wire [2:0]  o_obstacle_status
);

    // a stalled result stays put
    `URF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `URF_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_sensor_out) && $stable(o_raw_range) && $stable(o_smoothed_range) && $stable(o_obstacle_status), "stalled result changed")

    // reset empties the output register
    `URF_ASSERT_ALWAYS(a_rst_clear, !i_rst_n, !o_out_valid, "result valid after reset")

    // one word in flight: an accept closes the input side
    `URF_ASSERT_NEXT(a_one_busy, i_in_valid && o_in_ready, !o_in_ready, "input reopened right after accept")

    // a new result only appears at the end of a busy period
    `URF_ASSERT_NOW(a_rise_busy, $rose(o_out_valid), $past(!o_in_ready), "result without work")

endmodule

bind ultrasonic_range_filter urf_checker u_urf_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic range filter testbench
// Drives echo words on the four sensors and predicts each result word
// (checked raw range, smoothed range, obstacle status) from a local copy of
// the per-sensor filter state and the two registers. Results are compared
// field by field in arrival order while both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import urf_pkg::*;

    localparam int FB           = 8;        // fraction bits of all ranges
    localparam int DRAIN_CYCLES = 12;       // settle time after the last result
    localparam int HOLD_CYCLES  = 250;      // long receiver hold-off
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 500_000;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} t_rx_pattern;

    typedef struct {
        logic [SENSOR_W-1:0] sensor;
        logic [RANGE_W-1:0]  raw;
        logic [RANGE_W-1:0]  smoothed;
        t_obstacle           status;
    } t_range_report;

    // ------------------------------------------------------------------
    // clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic [SENSOR_W-1:0]    in_sensor = '0;
    logic                   in_echo_seen = 1'b0;
    logic [TIME_W-1:0]      in_echo_time = '0;
    logic                   out_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]       cfg_data = '0;

    wire                    o_in_ready;
    wire                    o_out_valid;
    wire [SENSOR_W-1:0]     o_sensor_out;
    wire [RANGE_W-1:0]      o_raw_range;
    wire [RANGE_W-1:0]      o_smoothed_range;
    wire [STATUS_W-1:0]     o_obstacle_status;
    wire                    o_cfg_ready;

    ultrasonic_range_filter #(.FRACTION_BITS(FB)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_sensor_index    (in_sensor),
        .i_echo_seen       (in_echo_seen),
        .i_echo_time_us    (in_echo_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_sensor_out      (o_sensor_out),
        .o_raw_range       (o_raw_range),
        .o_smoothed_range  (o_smoothed_range),
        .o_obstacle_status (o_obstacle_status),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor state: registers and per-sensor filter memory
    // ------------------------------------------------------------------
    logic [REG_W-1:0]     range_max_cm = RESET_MAX_CM;
    logic [REG_W-1:0]     block_thr_cm = RESET_THR_CM;
    logic [31:0]          cur_raw   [SENSOR_COUNT];
    logic [31:0]          prev_raw  [SENSOR_COUNT];
    logic [31:0]          filt      [SENSOR_COUNT];
    logic [SAMPLES_W-1:0] reads_seen[SENSOR_COUNT];

    t_range_report pending_reports[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned readings_sent  = 0;
    int unsigned burst_left     = 0;
    bit          sender_paced   = 1'b1;

    // receiver hold-off handshake between the test thread and the receiver
    int unsigned rx_hold_requests = 0;
    int unsigned rx_hold_served   = 0;
    int unsigned rx_hold_left     = 0;
    t_rx_pattern rx_mode          = RX_STEADY;
    int unsigned rx_mode_left     = 0;

    function automatic logic [31:0] fixed_cm(logic [REG_W-1:0] cm);
        return 32'(cm) << FB;
    endfunction

    // time -> range, with out-of-window and missing echoes forced to max
    function automatic logic [31:0] checked_range(logic seen, logic [TIME_W-1:0] t);
        longint unsigned t10;
        longint unsigned lim;
        longint unsigned v;
        t10 = t;
        t10 = t10 * 10;
        lim = range_max_cm;
        lim = lim * 582;
        if (!seen || t10 > lim)
            return fixed_cm(range_max_cm);
        v = (t10 << FB) / 582;
        if (v < (64'd2 << FB))
            return fixed_cm(range_max_cm);
        return v[31:0];
    endfunction

    function automatic bit sector_blocked(logic [SENSOR_W-1:0] k);
        return filt[k] < fixed_cm(block_thr_cm);
    endfunction

    function automatic t_obstacle obstacle_now();
        int n;
        n = 0;
        for (int k = 0; k < SENSOR_COUNT; k++)
            if (sector_blocked(k[SENSOR_W-1:0])) n++;
        if (n >= 3)                                             return OBS_TRAPPED;
        if (sector_blocked(SNS_LEFT) && sector_blocked(SNS_RIGHT)) return OBS_BOTH_SIDES;
        if (sector_blocked(SNS_FRONT))                          return OBS_FRONT;
        if (sector_blocked(SNS_LEFT))                           return OBS_LEFT;
        if (sector_blocked(SNS_RIGHT))                          return OBS_RIGHT;
        if (sector_blocked(SNS_BACK))                           return OBS_REAR;
        return OBS_CLEAR;
    endfunction

    // Spike filter plus EMA for one accepted word; queues the expected result.
    task automatic predict_report(logic [SENSOR_W-1:0] s, logic seen,
                                  logic [TIME_W-1:0] t);
        logic [31:0]     raw;
        logic [31:0]     d;
        longint unsigned c;
        longint unsigned p;
        longint unsigned v;
        longint unsigned f;
        t_range_report   r;
        raw = checked_range(seen, t);
        prev_raw[s] = cur_raw[s];
        cur_raw[s]  = raw;
        if (reads_seen[s] < SAMPLES_FULL)
            reads_seen[s] = reads_seen[s] + 1'b1;
        v = raw;
        if (reads_seen[s] == SAMPLES_FULL) begin
            c = cur_raw[s];
            p = prev_raw[s];
            d = (c > p) ? 32'(c - p) : 32'(p - c);
            // consistent: close in absolute terms or within 20 percent
            if (d < fixed_cm(15) || longint'(d) * 5 < p)
                v = (c + p) / 2;
            else if (c < p)
                v = (c * 2 + p * 3) / 5;        // drop: lean on the old read
            else
                v = (c + p) / 2;                // jump
        end
        f = filt[s];
        f = (f * 13 + v * 7) / 20;
        filt[s] = f[31:0];
        r.sensor   = s;
        r.raw      = raw[RANGE_W-1:0];
        r.smoothed = filt[s][RANGE_W-1:0];
        r.status   = obstacle_now();
        pending_reports.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus tasks (all called on a rising edge)
    // ------------------------------------------------------------------
    // One word on the input channel, with random gaps between bursts.
    task automatic send_reading(logic [SENSOR_W-1:0] s, logic seen,
                                logic [TIME_W-1:0] t);
        int unsigned gap;
        if (sender_paced) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 9);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        in_valid     <= 1'b1;
        in_sensor    <= s;
        in_echo_seen <= seen;
        in_echo_time <= t;
        do @(posedge i_clk); while (!o_in_ready);
        predict_report(s, seen, t);
        readings_sent++;
    endtask

    // Stop offering words and wait for every queued result, then let the
    // pipeline settle.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // valid is only dropped on the last write of a sequence, so a
    // back-to-back write never lowers and raises it in one step
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] data,
                                  bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MAX_RANGE: range_max_cm = data;
            REG_BLOCK_THR: block_thr_cm = data;
            default: ;
        endcase
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [REG_W-1:0] max_cm, logic [REG_W-1:0] thr_cm);
        wait_until_drained();
        write_register(REG_MAX_RANGE, max_cm, 1'b0);
        write_register(REG_BLOCK_THR, thr_cm, 1'b1);
    endtask

    function automatic logic [TIME_W-1:0] echo_for_cm(int unsigned cm);
        int unsigned t;
        int unsigned j;
        t = cm * 582 / 10;
        j = $urandom_range(0, t / 8);
        t = $urandom_range(0, 1) ? t + j : t - j;
        return (t > 65535) ? 16'hFFFF : t[TIME_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // Reset registers (400 cm, 30 cm): missing echo, edges of the 2 cm floor
    // and of the 400 cm ceiling (23280 us is exactly 400 cm).
    task automatic test_range_limits();
        send_reading(SNS_FRONT, 1'b0, 16'd5000);
        send_reading(SNS_RIGHT, 1'b1, 16'd0);
        send_reading(SNS_BACK,  1'b1, 16'd116);   // just under 2 cm
        send_reading(SNS_LEFT,  1'b1, 16'd117);   // just over 2 cm
        send_reading(SNS_FRONT, 1'b1, 16'd23280);
        send_reading(SNS_RIGHT, 1'b1, 16'd23281);
        send_reading(SNS_BACK,  1'b1, 16'hFFFF);
        send_reading(SNS_LEFT,  1'b0, 16'hFFFF);
    endtask

    // Back sensor already has two reads: drop, jump, close read, 20% read.
    task automatic test_spike_filter();
        send_reading(SNS_BACK, 1'b1, 16'd5820);    // 100 cm
        send_reading(SNS_BACK, 1'b1, 16'd2910);    // 50 cm, drop
        send_reading(SNS_BACK, 1'b1, 16'd11640);   // 200 cm, jump
        send_reading(SNS_BACK, 1'b1, 16'd11931);   // 205 cm, within 15 cm
        send_reading(SNS_BACK, 1'b1, 16'd9894);    // 170 cm, within 20 percent
    endtask

    task automatic test_register_extremes();
        configure(10'd1023, 10'd1023);             // everything blocked
        send_reading(SNS_FRONT, 1'b1, 16'hFFFF);   // over 1023 cm
        send_reading(SNS_LEFT,  1'b1, 16'd59538);  // just inside 1023 cm
        configure(10'd0, 10'd0);                   // every read becomes zero
        send_reading(SNS_RIGHT, 1'b1, 16'd117);
        send_reading(SNS_BACK,  1'b1, 16'd0);
        configure(10'd1, 10'd1023);
        send_reading(SNS_LEFT,  1'b1, 16'd50);
        // unused indexes must leave both registers alone
        wait_until_drained();
        write_register(REG_SPARE_A, 10'($urandom), 1'b0);
        write_register(REG_SPARE_B, 10'($urandom), 1'b1);
        send_reading(SNS_FRONT, 1'b1, 16'd300);
    endtask

    // Receiver holds off while words keep coming, so the block must stall
    // its input; afterwards the sender waits for the queue to empty.
    task automatic test_backpressure();
        configure(RESET_MAX_CM, RESET_THR_CM);
        sender_paced = 1'b0;
        rx_hold_requests <= rx_hold_requests + 1;
        repeat (40)
            send_reading(2'($urandom), 1'b1, echo_for_cm($urandom_range(2, 420)));
        sender_paced = 1'b1;
        wait_until_drained();
    endtask

    // Phases with fresh registers and a target distance per sensor; most
    // words track the targets so the filter and status see realistic
    // approaches, the rest are spikes, missing echoes and raw noise.
    task automatic test_random_traffic();
        int unsigned   stop_at;
        int unsigned   count;
        int unsigned   kind;
        int unsigned   target_cm[SENSOR_COUNT];
        logic [REG_W-1:0] max_cm;
        logic [REG_W-1:0] thr_cm;
        logic [SENSOR_W-1:0] s;
        stop_at = readings_sent + RANDOM_ITEMS;
        while (readings_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0:       max_cm = 10'd1023;
                1:       max_cm = 10'($urandom_range(0, 1));
                2:       max_cm = 10'd2;
                default: max_cm = 10'($urandom_range(150, 1023));
            endcase
            case ($urandom_range(0, 9))
                0:       thr_cm = 10'd0;
                1:       thr_cm = 10'd1023;
                default: thr_cm = 10'($urandom_range(10, 350));
            endcase
            configure(max_cm, thr_cm);
            for (int k = 0; k < SENSOR_COUNT; k++)
                target_cm[k] = $urandom_range(0, 3) == 0 ? $urandom_range(2, 40)
                                                          : $urandom_range(2, 600);
            count = $urandom_range(40, 120);
            repeat (count) begin
                s = 2'($urandom);
                if ($urandom_range(0, 32) == 0)
                    target_cm[s] = $urandom_range(2, 600);
                kind = $urandom_range(0, 99);
                if (kind < 70)
                    send_reading(s, 1'b1, echo_for_cm(target_cm[s]));
                else if (kind < 80)
                    send_reading(s, 1'b1, 16'($urandom_range(0, 40000)));
                else if (kind < 88)
                    send_reading(s, 1'b0, 16'($urandom));
                else
                    send_reading(s, 1'($urandom), 16'($urandom));
            end
        end
        wait_until_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            cur_raw[k]    = fixed_cm(RESET_MAX_CM);
            prev_raw[k]   = fixed_cm(RESET_MAX_CM);
            filt[k]       = fixed_cm(RESET_MAX_CM);
            reads_seen[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        test_range_limits();
        test_spike_filter();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        wait_until_drained();
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random ready pattern, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_served != rx_hold_requests) begin
            rx_hold_served <= rx_hold_served + 1;
            rx_hold_left   <= HOLD_CYCLES;
            out_ready      <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            out_ready    <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_pattern'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(16, 160);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_STEADY: out_ready <= 1'b1;
                RX_HALF:   out_ready <= 1'($urandom);
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
                default:   out_ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker: each accepted word against the oldest expectation
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_range_report r;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("word with nothing pending, sensor", 0, o_sensor_out);
            end else begin
                r = pending_reports.pop_front();
                if (o_sensor_out !== r.sensor)
                    flag_mismatch("sensor", r.sensor, o_sensor_out);
                if (o_raw_range !== r.raw)
                    flag_mismatch("raw range", r.raw, o_raw_range);
                if (o_smoothed_range !== r.smoothed)
                    flag_mismatch("smoothed range", r.smoothed, o_smoothed_range);
                if (o_obstacle_status !== r.status)
                    flag_mismatch("obstacle status", r.status, o_obstacle_status);
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/urf_pkg.sv
hdl/urf_state_mem.sv
hdl/urf_raw_conv.sv
hdl/urf_div5.sv
hdl/urf_status.sv
hdl/ultrasonic_range_filter.sv
hdl/urf_checker.sv
tb/sv/testbench.sv
